// ===== rtl/core/sps_pkg.sv =====
// Shared types and constants of the five-point stencil sum block.
`default_nettype none

package sps_pkg;

   localparam int SAMPLE_W    = 32;
   localparam int SUM_W       = 35;
   localparam int IDX_W       = 11;
   localparam int CSR_W       = 11;
   localparam int P1_W        = 34;
   localparam int P2_W        = 33;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [CSR_W-1:0] GRID_SIZE_RESET = 11'd1024;

   typedef struct packed {
      logic signed [P1_W-1:0] part_a;
      logic signed [P2_W-1:0] part_b;
      logic [IDX_W-1:0]       row;
      logic [IDX_W-1:0]       col;
      logic                   last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

// ===== rtl/core/sps_ram.sv =====
// Generic single-write, single-read RAM with registered read-first output.
`default_nettype none

module sps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1027
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sps_front.sv =====
// Front end: size register, grid position tracking, row stores and operand window.
`default_nettype none

module sps_front #(
   parameter int MAX_GRID = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [sps_pkg::CSR_W-1:0]            csr_grid_size,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [sps_pkg::SAMPLE_W-1:0]  req_sample_value,
   input  wire sps_pkg::qstat_type                   q_stat,
   output logic                                      push,
   output sps_pkg::entry_type                        push_entry
);

   localparam int DEPTH = MAX_GRID + 3;
   localparam int POS_W = $clog2(DEPTH);
   localparam int EXT_W = (POS_W > sps_pkg::CSR_W) ? POS_W : sps_pkg::CSR_W;
   localparam int SW    = sps_pkg::SAMPLE_W;

   logic [sps_pkg::CSR_W-1:0] grid_size_ff, grid_size_in;
   logic [POS_W-1:0]          row_ff, row_in;
   logic [POS_W-1:0]          col_ff, col_in;
   logic                      f_valid_ff, f_valid_in;
   logic [SW-1:0]             f_sample_ff, f_sample_in;
   logic [SW-1:0]             f_cen_ff, f_cen_in;
   logic [SW-1:0]             f_left_ff, f_left_in;
   logic [SW-1:0]             col0_ff, col0_in;
   logic [sps_pkg::IDX_W-1:0] f_row_ff, f_row_in;
   logic [sps_pkg::IDX_W-1:0] f_col_ff, f_col_in;
   logic                      f_last_ff, f_last_in;

   logic             accept;
   logic [EXT_W-1:0] size_ext;
   logic [EXT_W-1:0] max_ext;
   logic [EXT_W-1:0] eff_ext;
   logic [POS_W-1:0] eff_g;
   logic [POS_W-1:0] eff_g_p1;
   logic             is_result;
   logic [EXT_W-1:0] row_out_ext;
   logic [EXT_W-1:0] col_out_ext;
   logic [SW-1:0]    old_centre;
   logic [SW-1:0]    centre_rd;
   logic [SW-1:0]    upper_rd;
   logic [POS_W-1:0] centre_rd_addr;

   assign csr_ready = 1'b1;
   assign req_ready = !f_valid_ff || !q_stat.full;
   assign accept    = req_valid && req_ready;
   assign push      = f_valid_ff && !q_stat.full;

   always_comb begin
      size_ext = EXT_W'(grid_size_ff);
      max_ext  = EXT_W'(MAX_GRID);
      if (size_ext == '0) begin
         eff_ext = EXT_W'(1);
      end else if (size_ext > max_ext) begin
         eff_ext = max_ext;
      end else begin
         eff_ext = size_ext;
      end
      eff_g    = eff_ext[POS_W-1:0];
      eff_g_p1 = eff_g + 1'b1;
   end

   assign is_result = (row_ff >= POS_W'(2)) && (row_ff <= eff_g_p1) &&
                      (col_ff != '0) && (col_ff <= eff_g);

   assign old_centre     = (col_ff == '0) ? col0_ff : centre_rd;
   assign centre_rd_addr = col_ff + 1'b1;
   assign row_out_ext    = EXT_W'(row_ff - 1'b1);
   assign col_out_ext    = EXT_W'(col_ff);

   sps_ram #(
      .WIDTH (SW),
      .DEPTH (DEPTH)
   ) u_centre_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (req_sample_value),
      .rd_en   (accept),
      .rd_addr (centre_rd_addr),
      .rd_data (centre_rd)
   );

   sps_ram #(
      .WIDTH (SW),
      .DEPTH (DEPTH)
   ) u_upper_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (old_centre),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (upper_rd)
   );

   always_comb begin
      grid_size_in = grid_size_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      f_valid_in   = f_valid_ff;
      f_sample_in  = f_sample_ff;
      f_cen_in     = f_cen_ff;
      f_left_in    = f_left_ff;
      col0_in      = col0_ff;
      f_row_in     = f_row_ff;
      f_col_in     = f_col_ff;
      f_last_in    = f_last_ff;
      if (csr_valid) begin
         grid_size_in = csr_grid_size;
      end
      if (push) begin
         f_valid_in = 1'b0;
      end
      if (accept) begin
         f_valid_in  = is_result;
         f_sample_in = req_sample_value;
         f_cen_in    = old_centre;
         f_left_in   = f_cen_ff;
         f_row_in    = row_out_ext[sps_pkg::IDX_W-1:0];
         f_col_in    = col_out_ext[sps_pkg::IDX_W-1:0];
         f_last_in   = (row_ff == eff_g_p1) && (col_ff == eff_g);
         if (col_ff == '0) begin
            col0_in = req_sample_value;
         end
         if (col_ff >= eff_g_p1) begin
            col_in = '0;
            row_in = (row_ff >= eff_g_p1) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= sps_pkg::GRID_SIZE_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         f_valid_ff   <= 1'b0;
      end else begin
         grid_size_ff <= grid_size_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         f_valid_ff   <= f_valid_in;
      end
      f_sample_ff <= f_sample_in;
      f_cen_ff    <= f_cen_in;
      f_left_ff   <= f_left_in;
      col0_ff     <= col0_in;
      f_row_ff    <= f_row_in;
      f_col_ff    <= f_col_in;
      f_last_ff   <= f_last_in;
   end

   always_comb begin
      push_entry.part_a = $signed({{2{f_sample_ff[SW-1]}}, f_sample_ff}) +
                          $signed({{2{upper_rd[SW-1]}}, upper_rd}) +
                          $signed({{2{f_left_ff[SW-1]}}, f_left_ff});
      push_entry.part_b = $signed({f_cen_ff[SW-1], f_cen_ff}) +
                          $signed({centre_rd[SW-1], centre_rd});
      push_entry.row    = f_row_ff;
      push_entry.col    = f_col_ff;
      push_entry.last   = f_last_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/core/sps_queue.sv =====
// Two-entry queue that decouples the front end from the result stage.
`default_nettype none

module sps_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire sps_pkg::entry_type  push_entry,
   input  wire logic                pop,
   output sps_pkg::entry_type       head_entry,
   output sps_pkg::qstat_type       q_stat
);

   sps_pkg::entry_type                slot_ff [sps_pkg::QUEUE_DEPTH];
   logic [sps_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [sps_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [sps_pkg::QCNT_W-1:0]        count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = slot_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == sps_pkg::QCNT_W'(sps_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

endmodule

`default_nettype wire

// ===== rtl/core/sps_back.sv =====
// Result stage: final addition of the two partial sums into the output register.
`default_nettype none

module sps_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire sps_pkg::qstat_type                 q_stat,
   input  wire sps_pkg::entry_type                 head_entry,
   output logic                                    pop,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [sps_pkg::SUM_W-1:0]        rsp_stencil_sum,
   output logic        [sps_pkg::IDX_W-1:0]        rsp_out_row,
   output logic        [sps_pkg::IDX_W-1:0]        rsp_out_col,
   output logic                                    rsp_is_last
);

   logic                             valid_ff, valid_in;
   logic signed [sps_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [sps_pkg::IDX_W-1:0]        row_ff, row_in;
   logic [sps_pkg::IDX_W-1:0]        col_ff, col_in;
   logic                             last_ff, last_in;

   assign pop = !q_stat.empty && (!valid_ff || rsp_ready);

   always_comb begin
      valid_in = valid_ff;
      sum_in   = sum_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      last_in  = last_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         valid_in = 1'b1;
         sum_in   = $signed({head_entry.part_a[sps_pkg::P1_W-1], head_entry.part_a}) +
                    $signed({{2{head_entry.part_b[sps_pkg::P2_W-1]}}, head_entry.part_b});
         row_in   = head_entry.row;
         col_in   = head_entry.col;
         last_in  = head_entry.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      sum_ff  <= sum_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_stencil_sum = sum_ff;
   assign rsp_out_row     = row_ff;
   assign rsp_out_col     = col_ff;
   assign rsp_is_last     = last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/five_point_stencil_sum.sv =====
// Top level of the five-point stencil sum block.
// The block takes a padded grid of (G+2) x (G+2) signed 32-bit items in row-major
// order and, for every interior point, returns the exact 35-bit sum of the point
// and its four orthogonal neighbors with its row, its column and a last flag. One
// item is accepted every clock cycle unless the output stalls, a rate set by one
// read and one write a cycle per row store, RAMs of MAX_GRID+3 words that need no
// clearing after reset. A point's result passes the front register, the queue and
// the output register once the item below it is accepted. G is the size register,
// clamped to 1..MAX_GRID; the user changes it only between grids; not enforced.
`default_nettype none

module five_point_stencil_sum #(
   parameter int MAX_GRID = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [sps_pkg::CSR_W-1:0]            csr_grid_size,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [sps_pkg::SAMPLE_W-1:0]  req_sample_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [sps_pkg::SUM_W-1:0]          rsp_stencil_sum,
   output logic        [sps_pkg::IDX_W-1:0]          rsp_out_row,
   output logic        [sps_pkg::IDX_W-1:0]          rsp_out_col,
   output logic                                      rsp_is_last
);

   sps_pkg::qstat_type q_stat;
   sps_pkg::entry_type push_entry;
   sps_pkg::entry_type head_entry;
   logic               push;
   logic               pop;

   sps_front #(
      .MAX_GRID (MAX_GRID)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_grid_size    (csr_grid_size),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .q_stat           (q_stat),
      .push             (push),
      .push_entry       (push_entry)
   );

   sps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_stat     (q_stat)
   );

   sps_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_stencil_sum (rsp_stencil_sum),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_is_last     (rsp_is_last)
   );

endmodule

`default_nettype wire

// ===== rtl/core/sps_checker.sv =====
// Port-level assertions for the five-point stencil sum block and their bind.
`default_nettype none

module sps_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [sps_pkg::SUM_W-1:0]     rsp_stencil_sum,
   input wire logic [sps_pkg::IDX_W-1:0]     rsp_out_row,
   input wire logic [sps_pkg::IDX_W-1:0]     rsp_out_col,
   input wire logic                          rsp_is_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stencil_sum) &&
      $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_is_last))
      else $error("A stalled result item changed or vanished.");

   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_last |-> rsp_out_row == rsp_out_col)
      else $error("The last item of a grid is not on the diagonal corner.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("A result item is offered right after reset.");

endmodule

bind five_point_stencil_sum sps_checker u_sps_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_stencil_sum (rsp_stencil_sum),
   .rsp_out_row     (rsp_out_row),
   .rsp_out_col     (rsp_out_col),
   .rsp_is_last     (rsp_is_last)
);

`default_nettype wire
